>>> rtl/tar_pkg.sv
// ----------------------------------------------------------------------------
// tar_pkg
// Shared widths, index tables, codes and types of the tetrahedron
// aspect-ratio pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tar_pkg;

  localparam int COORD_BITS = 16;
  localparam int NUM_EDGES  = 6;
  localparam int NUM_PAIRS  = 15;
  localparam int VOL_PAIR   = 5;   // pair of edges 1 and 2

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int C2_W    = 2 * CROSS_W;
  localparam int LEN2_W  = PROD_W + 2;
  localparam int ROOTC_W = C2_W / 2;
  localparam int ROOTL_W = LEN2_W / 2;
  localparam int VP_W    = EDGE_W + CROSS_W;
  localparam int VOL_W   = VP_W + 2;

  localparam int GRP  = 4;
  localparam int NGRP = (NUM_PAIRS + GRP - 1) / GRP;

  localparam int ASP_W    = 32;
  localparam int ASP_FRAC = 16;
  localparam int Q_BITS   = ASP_W;
  localparam int CLO_W    = ROOTC_W / 2;
  localparam int CHI_W    = ROOTC_W - CLO_W;
  localparam int PROD2_W  = ROOTL_W + ROOTC_W;
  localparam int NUM_W    = PROD2_W + ASP_FRAC;
  localparam int HI_W     = NUM_W - Q_BITS;

  localparam int LEN_OUT_W = 17;
  localparam int ORIENT_W  = 2;

  localparam logic [ORIENT_W-1:0] ORIENT_ZERO = 2'd0;
  localparam logic [ORIENT_W-1:0] ORIENT_POS  = 2'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_NEG  = 2'd2;

  localparam logic [ASP_W-1:0] ASP_MAX     = {1'b0, {(ASP_W-1){1'b1}}};
  localparam logic [ASP_W-1:0] ASP_MIN_MAG = {1'b1, {(ASP_W-1){1'b0}}};
  localparam logic [LEN_OUT_W-1:0] LEN_MAX = {LEN_OUT_W{1'b1}};

  // edge i runs from corner EB[i] to corner EA[i]
  localparam int EA [NUM_EDGES] = '{1, 2, 3, 2, 3, 3};
  localparam int EB [NUM_EDGES] = '{0, 0, 0, 1, 1, 2};
  // edge pairs in (i < j) order
  localparam int PA [NUM_PAIRS] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 3, 3, 4};
  localparam int PB [NUM_PAIRS] = '{1, 2, 3, 4, 5, 2, 3, 4, 5, 3, 4, 5, 4, 5, 5};
  // cross product component k = a[NXT1]*b[NXT2] - a[NXT2]*b[NXT1]
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic signed [VOL_W-1:0] vol;
    logic [VOL_W-1:0]        vmag;
    logic                    vneg;
    logic                    vzero;
  } vol_t;

endpackage

`default_nettype wire

>>> rtl/tar_if.sv
// ----------------------------------------------------------------------------
// tar_if
// Valid/ready channels: tetrahedron corners in, quality results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tar_in_if;
  logic valid;
  logic ready;
  logic signed [tar_pkg::COORD_BITS-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [tar_pkg::COORD_BITS-1:0] x2, y2, z2, x3, y3, z3;

  modport source (output valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
                  input ready);
  modport sink (input valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
                output ready);
endinterface

interface tar_out_if;
  logic valid;
  logic ready;
  logic signed [tar_pkg::ASP_W-1:0]  aspect_ratio;
  logic signed [tar_pkg::VOL_W-1:0]  six_volume;
  logic [tar_pkg::ORIENT_W-1:0]      orientation;
  logic                              zero_volume;
  logic [tar_pkg::LEN_OUT_W-1:0]     max_edge_length;

  modport source (output valid, aspect_ratio, six_volume, orientation, zero_volume,
                  max_edge_length, input ready);
  modport sink (input valid, aspect_ratio, six_volume, orientation, zero_volume,
                max_edge_length, output ready);
endinterface

`default_nettype wire

>>> rtl/tet_aspect_ratio.sv
// Throughput: one tetrahedron per cycle unless the output stalls; every stage of the
// 78-deep pipeline takes a new item.
// A stall at the output freezes the whole pipeline, so no item is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the result register comes up empty.
// ----------------------------------------------------------------------------
// tet_aspect_ratio
// Tetrahedron aspect ratio, signed volume, orientation and longest edge.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_aspect_ratio (
  input  logic             clk,
  input  logic             rst_n,
  tar_in_if.sink           in_tet,
  tar_out_if.source        out_res
);

  logic en;
  logic signed [tar_pkg::COORD_BITS-1:0] pt [4][3];

  logic                          g_valid;
  logic [tar_pkg::C2_W-1:0]      g_c2;
  logic [tar_pkg::LEN2_W-1:0]    g_len2;
  tar_pkg::vol_t                 g_vol;

  logic                          r_valid;
  logic [tar_pkg::ROOTC_W-1:0]   r_croot;
  logic [tar_pkg::ROOTL_W-1:0]   r_lroot;
  tar_pkg::vol_t                 r_vol;

  logic                          d_valid;
  logic [tar_pkg::ROOTL_W-1:0]   d_len;
  logic [tar_pkg::Q_BITS-1:0]    d_quot;
  logic                          d_sat;
  tar_pkg::vol_t                 d_vol;

  logic                            out_valid_r;
  logic [tar_pkg::ASP_W-1:0]       aspect_r, aspect_nxt;
  logic [tar_pkg::VOL_W-1:0]       vol_r;
  logic [tar_pkg::ORIENT_W-1:0]    orient_r, orient_nxt;
  logic                            zero_r;
  logic [tar_pkg::LEN_OUT_W-1:0]   len_r, len_nxt;
  logic [tar_pkg::ASP_W-1:0]       mag;

  assign en           = !out_valid_r || out_res.ready;
  assign in_tet.ready = en;

  assign pt[0][0] = in_tet.x0;
  assign pt[0][1] = in_tet.y0;
  assign pt[0][2] = in_tet.z0;
  assign pt[1][0] = in_tet.x1;
  assign pt[1][1] = in_tet.y1;
  assign pt[1][2] = in_tet.z1;
  assign pt[2][0] = in_tet.x2;
  assign pt[2][1] = in_tet.y2;
  assign pt[2][2] = in_tet.z2;
  assign pt[3][0] = in_tet.x3;
  assign pt[3][1] = in_tet.y3;
  assign pt[3][2] = in_tet.z3;

  tar_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tet.valid),
    .pt        (pt),
    .out_valid (g_valid),
    .c2_max    (g_c2),
    .len2_max  (g_len2),
    .vol       (g_vol)
  );

  tar_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid),
    .c2        (g_c2),
    .len2      (g_len2),
    .vol_in    (g_vol),
    .out_valid (r_valid),
    .croot     (r_croot),
    .lroot     (r_lroot),
    .vol_out   (r_vol)
  );

  tar_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r_valid),
    .lroot     (r_lroot),
    .croot     (r_croot),
    .vol_in    (r_vol),
    .out_valid (d_valid),
    .len       (d_len),
    .quot      (d_quot),
    .sat       (d_sat),
    .vol_out   (d_vol)
  );

  always_comb begin
    mag        = d_quot;
    aspect_nxt = d_quot;
    orient_nxt = tar_pkg::ORIENT_POS;
    if (d_vol.vzero) begin
      aspect_nxt = tar_pkg::ASP_MAX;
      orient_nxt = tar_pkg::ORIENT_ZERO;
    end else if (!d_vol.vneg) begin
      if (d_sat || d_quot > tar_pkg::ASP_MAX) begin
        aspect_nxt = tar_pkg::ASP_MAX;
      end
    end else begin
      orient_nxt = tar_pkg::ORIENT_NEG;
      if (d_sat || d_quot > tar_pkg::ASP_MIN_MAG) begin
        mag = tar_pkg::ASP_MIN_MAG;
      end
      aspect_nxt = -mag;
    end
    if (d_len > tar_pkg::ROOTL_W'(tar_pkg::LEN_MAX)) begin
      len_nxt = tar_pkg::LEN_MAX;
    end else begin
      len_nxt = tar_pkg::LEN_OUT_W'(d_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aspect_r <= aspect_nxt;
      vol_r    <= d_vol.vol;
      orient_r <= orient_nxt;
      zero_r   <= d_vol.vzero;
      len_r    <= len_nxt;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.aspect_ratio    = aspect_r;
  assign out_res.six_volume      = vol_r;
  assign out_res.orientation     = orient_r;
  assign out_res.zero_volume     = zero_r;
  assign out_res.max_edge_length = len_r;

`ifndef ASSERT_OFF
  a_zero_orient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (zero_r == (orient_r == tar_pkg::ORIENT_ZERO)))
    else $error("zero volume flag and orientation disagree");

  a_pos_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (orient_r == tar_pkg::ORIENT_POS) |-> !aspect_r[tar_pkg::ASP_W-1])
    else $error("positive orientation with negative aspect ratio");

  a_neg_volume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (orient_r == tar_pkg::ORIENT_NEG) |-> vol_r[tar_pkg::VOL_W-1])
    else $error("negative orientation with non-negative volume");
`endif

endmodule

`default_nettype wire

>>> rtl/tar_geom.sv
// ----------------------------------------------------------------------------
// tar_geom
// Seven-stage front end: edges, cross products, squared norms, the two
// maxima and six times the signed volume.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_geom (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic signed [tar_pkg::COORD_BITS-1:0] pt [4][3],
  output logic out_valid,
  output logic [tar_pkg::C2_W-1:0]   c2_max,
  output logic [tar_pkg::LEN2_W-1:0] len2_max,
  output tar_pkg::vol_t              vol
);

  logic [6:0] v_r;

  logic signed [tar_pkg::EDGE_W-1:0]  e_r   [tar_pkg::NUM_EDGES][3];
  logic signed [tar_pkg::PROD_W-1:0]  m_r   [tar_pkg::NUM_PAIRS][3][2];
  logic [tar_pkg::PROD_W-1:0]         sq_r  [tar_pkg::NUM_EDGES][3];
  logic signed [tar_pkg::EDGE_W-1:0]  e0a_r [3];
  logic signed [tar_pkg::CROSS_W-1:0] c_r   [tar_pkg::NUM_PAIRS][3];
  logic [tar_pkg::LEN2_W-1:0]         l2_r  [tar_pkg::NUM_EDGES];
  logic signed [tar_pkg::EDGE_W-1:0]  e0b_r [3];
  logic [tar_pkg::C2_W-1:0]           csq_r [tar_pkg::NUM_PAIRS][3];
  logic signed [tar_pkg::VP_W-1:0]    vp_r  [3];
  logic [tar_pkg::LEN2_W-1:0]         l2b_r [tar_pkg::NUM_EDGES];
  logic [tar_pkg::C2_W-1:0]           c2_r  [tar_pkg::NUM_PAIRS];
  logic signed [tar_pkg::VOL_W-1:0]   vol_r;
  logic [tar_pkg::LEN2_W-1:0]         l2c_r [tar_pkg::NUM_EDGES];
  logic [tar_pkg::C2_W-1:0]           g_r   [tar_pkg::NGRP];
  logic [tar_pkg::LEN2_W-1:0]         lm_r;
  tar_pkg::vol_t                      vol6_r;
  logic [tar_pkg::C2_W-1:0]           c2m_r;
  logic [tar_pkg::LEN2_W-1:0]         lm7_r;
  tar_pkg::vol_t                      vol7_r;

  logic [tar_pkg::C2_W-1:0]   gmax [tar_pkg::NGRP];
  logic [tar_pkg::LEN2_W-1:0] lmax;
  logic [tar_pkg::C2_W-1:0]   cmax;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // stage 1 edges, stage 2 products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tar_pkg::NUM_EDGES; i++) begin
        for (int k = 0; k < 3; k++) begin
          e_r[i][k]  <= pt[tar_pkg::EA[i]][k] - pt[tar_pkg::EB[i]][k];
          sq_r[i][k] <= e_r[i][k] * e_r[i][k];
        end
      end
      for (int q = 0; q < tar_pkg::NUM_PAIRS; q++) begin
        for (int k = 0; k < 3; k++) begin
          m_r[q][k][0] <= e_r[tar_pkg::PA[q]][tar_pkg::NXT1[k]] *
                          e_r[tar_pkg::PB[q]][tar_pkg::NXT2[k]];
          m_r[q][k][1] <= e_r[tar_pkg::PA[q]][tar_pkg::NXT2[k]] *
                          e_r[tar_pkg::PB[q]][tar_pkg::NXT1[k]];
        end
      end
      for (int k = 0; k < 3; k++) begin
        e0a_r[k] <= e_r[0][k];
      end
    end
  end

  // stage 3 cross products and edge lengths, stage 4 squares and volume products, stage 5 sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < tar_pkg::NUM_PAIRS; q++) begin
        for (int k = 0; k < 3; k++) begin
          c_r[q][k]   <= m_r[q][k][0] - m_r[q][k][1];
          csq_r[q][k] <= c_r[q][k] * c_r[q][k];
        end
        c2_r[q] <= csq_r[q][0] + csq_r[q][1] + csq_r[q][2];
      end
      for (int i = 0; i < tar_pkg::NUM_EDGES; i++) begin
        l2_r[i]  <= tar_pkg::LEN2_W'(sq_r[i][0]) + tar_pkg::LEN2_W'(sq_r[i][1]) +
                    tar_pkg::LEN2_W'(sq_r[i][2]);
        l2b_r[i] <= l2_r[i];
        l2c_r[i] <= l2b_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        e0b_r[k] <= e0a_r[k];
        vp_r[k]  <= e0b_r[k] * c_r[tar_pkg::VOL_PAIR][k];
      end
      vol_r <= tar_pkg::VOL_W'(vp_r[0]) + tar_pkg::VOL_W'(vp_r[1]) +
               tar_pkg::VOL_W'(vp_r[2]);
    end
  end

  always_comb begin
    for (int g = 0; g < tar_pkg::NGRP; g++) begin
      gmax[g] = '0;
      for (int j = 0; j < tar_pkg::GRP; j++) begin
        if (g * tar_pkg::GRP + j < tar_pkg::NUM_PAIRS) begin
          if (c2_r[g * tar_pkg::GRP + j] > gmax[g]) begin
            gmax[g] = c2_r[g * tar_pkg::GRP + j];
          end
        end
      end
    end
    lmax = '0;
    for (int i = 0; i < tar_pkg::NUM_EDGES; i++) begin
      if (l2c_r[i] > lmax) begin
        lmax = l2c_r[i];
      end
    end
    cmax = '0;
    for (int g = 0; g < tar_pkg::NGRP; g++) begin
      if (g_r[g] > cmax) begin
        cmax = g_r[g];
      end
    end
  end

  // stage 6 group maxima, edge length maximum and volume sign, stage 7 final maximum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < tar_pkg::NGRP; g++) begin
        g_r[g] <= gmax[g];
      end
      lm_r         <= lmax;
      vol6_r.vol   <= vol_r;
      vol6_r.vneg  <= vol_r[tar_pkg::VOL_W-1];
      vol6_r.vmag  <= vol_r[tar_pkg::VOL_W-1] ? $unsigned(-vol_r) : $unsigned(vol_r);
      vol6_r.vzero <= (vol_r == '0);
      c2m_r  <= cmax;
      lm7_r  <= lm_r;
      vol7_r <= vol6_r;
    end
  end

  assign out_valid = v_r[6];
  assign c2_max    = c2m_r;
  assign len2_max  = lm7_r;
  assign vol       = vol7_r;

endmodule

`default_nettype wire

>>> rtl/tar_root.sv
// ----------------------------------------------------------------------------
// tar_root
// Pipelined integer square roots, one result bit per stage, for the
// largest squared cross product and the largest squared edge length.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_root (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [tar_pkg::C2_W-1:0]   c2,
  input  logic [tar_pkg::LEN2_W-1:0] len2,
  input  tar_pkg::vol_t              vol_in,
  output logic out_valid,
  output logic [tar_pkg::ROOTC_W-1:0] croot,
  output logic [tar_pkg::ROOTL_W-1:0] lroot,
  output tar_pkg::vol_t               vol_out
);

  localparam int NS     = tar_pkg::ROOTC_W;
  localparam int KC     = tar_pkg::ROOTC_W;
  localparam int KL     = tar_pkg::ROOTL_W;
  localparam int CREM_W = KC + 1;
  localparam int LREM_W = KL + 1;

  logic [NS-1:0]                v_r;
  logic [tar_pkg::C2_W-1:0]     cn_r    [NS];
  logic [CREM_W-1:0]            crem_r  [NS];
  logic [KC-1:0]                croot_r [NS];
  logic [tar_pkg::LEN2_W-1:0]   ln_r    [NS];
  logic [LREM_W-1:0]            lrem_r  [NS];
  logic [KL-1:0]                lroot_r [NS];
  tar_pkg::vol_t                vol_r   [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [tar_pkg::C2_W-1:0]   cn_s;
    logic [CREM_W-1:0]          crem_s;
    logic [KC-1:0]              croot_s;
    logic [tar_pkg::LEN2_W-1:0] ln_s;
    logic [LREM_W-1:0]          lrem_s;
    logic [KL-1:0]              lroot_s;
    tar_pkg::vol_t              vol_s;
    logic [CREM_W+1:0]          crt;
    logic [KC+1:0]              ctr;
    logic [LREM_W+1:0]          lrt;
    logic [KL+1:0]              ltr;
    logic [CREM_W-1:0]          crem_nxt;
    logic [KC-1:0]              croot_nxt;
    logic [LREM_W-1:0]          lrem_nxt;
    logic [KL-1:0]              lroot_nxt;

    if (s == 0) begin : g_src
      assign cn_s    = c2;
      assign crem_s  = '0;
      assign croot_s = '0;
      assign ln_s    = len2;
      assign lrem_s  = '0;
      assign lroot_s = '0;
      assign vol_s   = vol_in;
    end else begin : g_src
      assign cn_s    = cn_r[s-1];
      assign crem_s  = crem_r[s-1];
      assign croot_s = croot_r[s-1];
      assign ln_s    = ln_r[s-1];
      assign lrem_s  = lrem_r[s-1];
      assign lroot_s = lroot_r[s-1];
      assign vol_s   = vol_r[s-1];
    end

    always_comb begin
      crt = {crem_s, cn_s[tar_pkg::C2_W-1 -: 2]};
      ctr = {croot_s, 2'b01};
      if (crt >= (CREM_W+2)'(ctr)) begin
        crem_nxt  = CREM_W'(crt - (CREM_W+2)'(ctr));
        croot_nxt = {croot_s[KC-2:0], 1'b1};
      end else begin
        crem_nxt  = CREM_W'(crt);
        croot_nxt = {croot_s[KC-2:0], 1'b0};
      end
      lrt = {lrem_s, ln_s[tar_pkg::LEN2_W-1 -: 2]};
      ltr = {lroot_s, 2'b01};
      lrem_nxt  = lrem_s;
      lroot_nxt = lroot_s;
      if (s < KL) begin
        if (lrt >= (LREM_W+2)'(ltr)) begin
          lrem_nxt  = LREM_W'(lrt - (LREM_W+2)'(ltr));
          lroot_nxt = {lroot_s[KL-2:0], 1'b1};
        end else begin
          lrem_nxt  = LREM_W'(lrt);
          lroot_nxt = {lroot_s[KL-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cn_r[s]    <= cn_s << 2;
        crem_r[s]  <= crem_nxt;
        croot_r[s] <= croot_nxt;
        ln_r[s]    <= ln_s << 2;
        lrem_r[s]  <= lrem_nxt;
        lroot_r[s] <= lroot_nxt;
        vol_r[s]   <= vol_s;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign croot     = croot_r[NS-1];
  assign lroot     = lroot_r[NS-1];
  assign vol_out   = vol_r[NS-1];

endmodule

`default_nettype wire

>>> rtl/tar_div.sv
// ----------------------------------------------------------------------------
// tar_div
// Numerator product in two partial products, overflow check, then a
// restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_div (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [tar_pkg::ROOTL_W-1:0] lroot,
  input  logic [tar_pkg::ROOTC_W-1:0] croot,
  input  tar_pkg::vol_t               vol_in,
  output logic out_valid,
  output logic [tar_pkg::ROOTL_W-1:0] len,
  output logic [tar_pkg::Q_BITS-1:0]  quot,
  output logic                        sat,
  output tar_pkg::vol_t               vol_out
);

  localparam int DS    = tar_pkg::Q_BITS;
  localparam int VW    = tar_pkg::VOL_W;
  localparam int PL_W  = tar_pkg::ROOTL_W + tar_pkg::CLO_W;
  localparam int PH_W  = tar_pkg::ROOTL_W + tar_pkg::CHI_W;

  logic [2:0]                   vm_r;
  logic [PL_W-1:0]              pl_r;
  logic [PH_W-1:0]              ph_r;
  logic [tar_pkg::ROOTL_W-1:0]  l1_r, l2_r, l3_r;
  tar_pkg::vol_t                v1_r, v2_r, v3_r;
  logic [tar_pkg::NUM_W-1:0]    num_r;
  logic                         sat3_r;
  logic [VW-1:0]                rem3_r;
  logic [tar_pkg::Q_BITS-1:0]   lo3_r;

  logic [DS-1:0]                vd_r;
  logic [VW-1:0]                rem_r  [DS];
  logic [tar_pkg::Q_BITS-1:0]   lo_r   [DS];
  logic [tar_pkg::Q_BITS-1:0]   q_r    [DS];
  logic                         sat_r  [DS];
  logic [tar_pkg::ROOTL_W-1:0]  len_r  [DS];
  tar_pkg::vol_t                vol_r  [DS];

  logic [tar_pkg::PROD2_W-1:0]  prod;
  logic [tar_pkg::HI_W-1:0]     num_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= '0;
      vd_r <= '0;
    end else if (en) begin
      vm_r <= {vm_r[1:0], in_valid};
      vd_r <= {vd_r[DS-2:0], vm_r[2]};
    end
  end

  assign prod   = (tar_pkg::PROD2_W'(ph_r) << tar_pkg::CLO_W) + tar_pkg::PROD2_W'(pl_r);
  assign num_hi = num_r[tar_pkg::NUM_W-1:tar_pkg::Q_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= PL_W'(lroot) * PL_W'(croot[tar_pkg::CLO_W-1:0]);
      ph_r   <= PH_W'(lroot) * PH_W'(croot[tar_pkg::ROOTC_W-1:tar_pkg::CLO_W]);
      l1_r   <= lroot;
      v1_r   <= vol_in;
      num_r  <= {prod, {tar_pkg::ASP_FRAC{1'b0}}};
      l2_r   <= l1_r;
      v2_r   <= v1_r;
      // quotient needs more than Q_BITS bits
      sat3_r <= (VW'(num_hi) >= v2_r.vmag);
      rem3_r <= VW'(num_hi);
      lo3_r  <= num_r[tar_pkg::Q_BITS-1:0];
      l3_r   <= l2_r;
      v3_r   <= v2_r;
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_st
    logic [VW-1:0]                rem_s;
    logic [tar_pkg::Q_BITS-1:0]   lo_s;
    logic [tar_pkg::Q_BITS-1:0]   q_s;
    logic                         sat_s;
    logic [tar_pkg::ROOTL_W-1:0]  len_s;
    tar_pkg::vol_t                vol_s;
    logic [VW:0]                  rt;
    logic [VW-1:0]                rem_nxt;
    logic                         qb;

    if (s == 0) begin : g_src
      assign rem_s = rem3_r;
      assign lo_s  = lo3_r;
      assign q_s   = '0;
      assign sat_s = sat3_r;
      assign len_s = l3_r;
      assign vol_s = v3_r;
    end else begin : g_src
      assign rem_s = rem_r[s-1];
      assign lo_s  = lo_r[s-1];
      assign q_s   = q_r[s-1];
      assign sat_s = sat_r[s-1];
      assign len_s = len_r[s-1];
      assign vol_s = vol_r[s-1];
    end

    always_comb begin
      rt = {rem_s, lo_s[tar_pkg::Q_BITS-1]};
      qb = (rt >= {1'b0, vol_s.vmag});
      if (qb) begin
        rem_nxt = VW'(rt - {1'b0, vol_s.vmag});
      end else begin
        rem_nxt = VW'(rt);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        lo_r[s]  <= lo_s << 1;
        q_r[s]   <= {q_s[tar_pkg::Q_BITS-2:0], qb};
        sat_r[s] <= sat_s;
        len_r[s] <= len_s;
        vol_r[s] <= vol_s;
      end
    end
  end

  assign out_valid = vd_r[DS-1];
  assign len       = len_r[DS-1];
  assign quot      = q_r[DS-1];
  assign sat       = sat_r[DS-1];
  assign vol_out   = vol_r[DS-1];

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams tetrahedra through tet_aspect_ratio. Each result is checked
// against a local computation of the aspect ratio, six times the signed
// volume, the orientation and the longest edge. The input and output sides
// idle at random. The output side also holds off for a long stretch, so the
// pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_LEN     = 300;

  typedef logic signed [tar_pkg::COORD_BITS-1:0] coord_t;
  typedef struct {
    coord_t c [12];  // x0 y0 z0 x1 y1 z1 ... z3
  } tet_t;
  typedef struct {
    logic [tar_pkg::ASP_W-1:0]     aspect;
    logic [tar_pkg::VOL_W-1:0]     vol6;
    logic [tar_pkg::ORIENT_W-1:0]  orient;
    logic                          flat;
    logic [tar_pkg::LEN_OUT_W-1:0] len;
  } quality_t;

  logic clk = 0;
  logic rst_n = 0;
  tar_in_if  in_ch ();
  tar_out_if out_ch ();

  tet_aspect_ratio dut (.clk(clk), .rst_n(rst_n), .in_tet(in_ch.sink), .out_res(out_ch.source));

  always #5 clk = ~clk;

  quality_t pending_q [$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int rx_wait = 0;
  bit no_idle = 0;

  function automatic logic [63:0] root(logic [127:0] n);
    logic [63:0] r, t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ((128'(t) * 128'(t)) <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] sq(longint signed v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return 128'(m) * 128'(m);
  endfunction

  function automatic quality_t tet_quality(tet_t t);
    int ea [6] = '{1, 2, 3, 2, 3, 3};
    int eb [6] = '{0, 0, 0, 1, 1, 2};
    longint signed e [6][3];
    longint signed cr [3];
    longint signed vol;
    longint unsigned l2, maxl2;
    logic [127:0] s, maxc2, num, q, m;
    logic [63:0] len, cm, vmag;
    quality_t r;
    maxl2 = 0;
    maxc2 = 0;
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 3; k++)
        e[i][k] = longint'(t.c[ea[i]*3+k]) - longint'(t.c[eb[i]*3+k]);
    for (int i = 0; i < 6; i++) begin
      l2 = 0;
      for (int k = 0; k < 3; k++) l2 += longint'(e[i][k] * e[i][k]);
      if (l2 > maxl2) maxl2 = l2;
    end
    for (int i = 0; i < 5; i++)
      for (int j = i + 1; j < 6; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++)
          s += sq(e[i][(k+1)%3] * e[j][(k+2)%3] - e[i][(k+2)%3] * e[j][(k+1)%3]);
        if (s > maxc2) maxc2 = s;
      end
    for (int k = 0; k < 3; k++)
      cr[k] = e[1][(k+1)%3] * e[2][(k+2)%3] - e[1][(k+2)%3] * e[2][(k+1)%3];
    vol = e[0][0] * cr[0] + e[0][1] * cr[1] + e[0][2] * cr[2];
    vmag = (vol < 0) ? -vol : vol;
    len = root(128'(maxl2));
    cm = root(maxc2);
    if (vol == 0) begin
      r.aspect = tar_pkg::ASP_MAX;
      r.orient = tar_pkg::ORIENT_ZERO;
    end else begin
      num = (128'(len) * 128'(cm)) << tar_pkg::ASP_FRAC;
      q = num / 128'(vmag);
      if (vol > 0) begin
        r.aspect = (q > 128'(tar_pkg::ASP_MAX)) ? tar_pkg::ASP_MAX : q[tar_pkg::ASP_W-1:0];
        r.orient = tar_pkg::ORIENT_POS;
      end else begin
        m = (q > 128'(tar_pkg::ASP_MIN_MAG)) ? 128'(tar_pkg::ASP_MIN_MAG) : q;
        r.aspect = -m[tar_pkg::ASP_W-1:0];
        r.orient = tar_pkg::ORIENT_NEG;
      end
    end
    r.vol6 = tar_pkg::VOL_W'(vol);
    r.flat = (vol == 0);
    r.len = (len > 64'(tar_pkg::LEN_MAX)) ? tar_pkg::LEN_MAX : len[tar_pkg::LEN_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_tet(tet_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.x0, in_ch.y0, in_ch.z0, in_ch.x1, in_ch.y1, in_ch.z1} <=
      {t.c[0], t.c[1], t.c[2], t.c[3], t.c[4], t.c[5]};
    {in_ch.x2, in_ch.y2, in_ch.z2, in_ch.x3, in_ch.y3, in_ch.z3} <=
      {t.c[6], t.c[7], t.c[8], t.c[9], t.c[10], t.c[11]};
    do @(posedge clk); while (!in_ch.ready);
    pending_q.insert(pending_q.size(), tet_quality(t));
  endtask

  function automatic tet_t make_tet(int lo, int hi);
    tet_t t;
    for (int i = 0; i < 12; i++) t.c[i] = coord_t'($urandom_range(hi - lo, 0) + lo);
    return t;
  endfunction

  function automatic tet_t full_tet();
    tet_t t;
    for (int i = 0; i < 12; i++) t.c[i] = coord_t'($urandom);
    return t;
  endfunction

  function automatic tet_t tet_of(int v [12]);
    tet_t t;
    for (int i = 0; i < 12; i++) t.c[i] = coord_t'(v[i]);
    return t;
  endfunction

  // output side: per-transfer random wait plus an optional long hold
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result aspect %h", $time, out_ch.aspect_ratio);
        errors++;
      end else begin
        quality_t x;
        x = pending_q.pop_front();
        if (out_ch.aspect_ratio !== x.aspect) begin
          $display("%0t: aspect_ratio exp %h got %h", $time, x.aspect, out_ch.aspect_ratio);
          errors++;
        end
        if (out_ch.six_volume !== x.vol6) begin
          $display("%0t: six_volume exp %h got %h", $time, x.vol6, out_ch.six_volume);
          errors++;
        end
        if (out_ch.orientation !== x.orient) begin
          $display("%0t: orientation exp %0d got %0d", $time, x.orient, out_ch.orientation);
          errors++;
        end
        if (out_ch.zero_volume !== x.flat) begin
          $display("%0t: zero_volume exp %b got %b", $time, x.flat, out_ch.zero_volume);
          errors++;
        end
        if (out_ch.max_edge_length !== x.len) begin
          $display("%0t: max_edge_length exp %h got %h", $time, x.len, out_ch.max_edge_length);
          errors++;
        end
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 4);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (rx_wait == 0);
    end
  end

  task automatic test_directed();
    int maxc = 32767;
    int minc = -32768;
    send_tet(tet_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_tet(tet_of('{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256}));
    send_tet(tet_of('{0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256}));
    send_tet(tet_of('{minc, minc, minc, maxc, minc, minc, minc, maxc, minc, minc, minc, maxc}));
    send_tet(tet_of('{maxc, maxc, maxc, minc, maxc, maxc, maxc, minc, maxc, maxc, maxc, minc}));
    send_tet(tet_of('{minc, minc, minc, maxc, maxc, maxc, minc, maxc, minc, maxc, minc, maxc}));
    send_tet(tet_of('{0, 0, 0, 1, 2, 3, 2, 4, 6, 5, 1, 7}));
    send_tet(tet_of('{minc, minc, minc, maxc, maxc, maxc, 0, 0, 1, 1, 0, 0}));
    send_tet(tet_of('{minc, minc, minc, maxc, maxc, maxc, 0, 1, 0, 1, 0, 0}));
    send_tet(tet_of('{minc, 0, 0, maxc, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_tet(tet_of('{minc, 0, 0, maxc, 0, 0, 0, 0, 1, 0, 1, 0}));
    send_tet(tet_of('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_tet(tet_of('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
    send_tet(tet_of('{256, 256, 0, -256, -256, 0, 256, -256, 0, 0, 0, 0}));
    send_tet(tet_of('{256, 256, 256, -256, -256, 256, -256, 256, -256, 256, -256, -256}));
    send_tet(tet_of('{256, 256, 256, -256, 256, -256, -256, -256, 256, 256, -256, -256}));
  endtask

  task automatic test_random(int n);
    tet_t t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: t = full_tet();
        1: t = make_tet(-512, 512);
        2: t = make_tet(-4, 4);
        default: begin
          t = full_tet();
          for (int k = 0; k < 3; k++) t.c[9+k] = t.c[k] + (t.c[3+k] - t.c[k]);
        end
      endcase
      send_tet(t);
    end
  endtask

  task automatic test_backpressure();
    hold_req++;
    no_idle = 1;
    test_random(200);
    no_idle = 0;
  endtask

  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    test_random(50);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    {in_ch.x0, in_ch.y0, in_ch.z0, in_ch.x1, in_ch.y1, in_ch.z1} <= '0;
    {in_ch.x2, in_ch.y2, in_ch.z2, in_ch.x3, in_ch.y3, in_ch.z3} <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_drain_pause();
    test_random(100);
    in_ch.valid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
